// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is low.
`define GPDF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that is checked in every cycle, reset included.
`define GPDF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/gpdf_pkg.sv -----
// ============================================================================
// Gaussian evaluator package
// Shared widths, fixed-point constants, register codes and the exp table.
// ============================================================================
`default_nettype none

package gpdf_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int Z_W       = 31;            // |z| in Q3.28
    localparam int PHI_W     = 30;            // density kernel in Q30
    localparam int DIV_STEPS = 31;            // quotient bits per division
    localparam int Q_SHIFT   = 30 - FRAC_W;   // Q30 to output format

    localparam logic [30:0] ONE30        = 31'h4000_0000;
    localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
    localparam logic [28:0] INV_SQRT_2PI = 29'd428361012;
    localparam logic [27:0] TAIL_P       = 28'd248723596;
    localparam logic [31:0] TAIL_REM0    = 32'h2000_0000;
    localparam logic [31:0] CDF_ONE      = 32'(ONE30 >> Q_SHIFT);

    localparam logic signed [33:0] AS_C0 = 34'sd342933307;
    localparam logic signed [33:0] AS_C1 = -34'sd382857446;
    localparam logic signed [33:0] AS_C2 = 34'sd1912847370;
    localparam logic signed [33:0] AS_C3 = -34'sd1955558716;
    localparam logic signed [33:0] AS_C4 = 34'sd1428371292;

    typedef enum logic [1:0] {
        REG_MEAN  = 2'd0,
        REG_SIGMA = 2'd1,
        REG_MODE  = 2'd2
    } gpdf_reg_t;

    // Item context that rides along the dividers and the tail polynomial pipeline.
    typedef struct packed {
        logic              far;
        logic              neg;
        logic [PHI_W-1:0]  phi;
    } gpdf_tag_t;

    typedef struct packed {
        logic              far;
        logic              neg;
        logic [Z_W-1:0]    z;
    } gpdf_side_t;

    // exp(-2^j/8) in Q30.
    function automatic logic [29:0] exp_tbl(input logic [2:0] idx);
        logic [29:0] v;
        unique case (idx)
            3'd0: v = 30'd947573834;
            3'd1: v = 30'd836230973;
            3'd2: v = 30'd651257337;
            3'd3: v = 30'd395007542;
            3'd4: v = 30'd145315154;
            3'd5: v = 30'd19666267;
            3'd6: v = 30'd360200;
            default: v = 30'd121;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gpdf_front.sv -----
// ============================================================================
// Gaussian evaluator front end
// Distance from the mean, its sign, and the far-tail test, in three stages.
// ============================================================================
`default_nettype none

module gpdf_front (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] in_x,
    input  wire logic [31:0] mean,
    input  wire logic [30:0] sigma,
    output logic             out_valid,
    output logic [31:0]      out_mag,
    output logic             out_neg,
    output logic             out_far
);
    import gpdf_pkg::*;

    logic [2:0]  vld_reg;
    logic [32:0] diff_reg, diff_next;
    logic [31:0] mag1_reg, mag1_next, mag2_reg;
    logic        neg1_reg, neg2_reg, far_reg, far_next;

    always_comb begin
        diff_next = {in_x[31], in_x} - {mean[31], mean};
        mag1_next = diff_reg[32] ? 32'(-diff_reg) : diff_reg[31:0];
        // The quotient reaches 8 exactly when the distance is eight sigmas or more.
        far_next  = {2'b00, mag1_reg} >= {sigma, 3'b000};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
        if (en) begin
            diff_reg <= diff_next;
            mag1_reg <= mag1_next;
            neg1_reg <= diff_reg[32];
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            far_reg  <= far_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_mag   = mag2_reg;
    assign out_neg   = neg2_reg;
    assign out_far   = far_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gpdf_div.sv -----
// ============================================================================
// Gaussian evaluator divider
// Restoring division, one quotient bit per pipeline stage.
// ============================================================================
`default_nettype none

module gpdf_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [31:0]        in_rem,
    input  wire logic [30:0]        in_num,
    input  wire logic [31:0]        in_dvs,
    input  wire gpdf_pkg::gpdf_tag_t in_tag,
    output logic                    out_valid,
    output logic [30:0]             out_quo,
    output gpdf_pkg::gpdf_tag_t     out_tag
);
    import gpdf_pkg::*;

    logic [DIV_STEPS-1:0] vld_reg;
    logic [31:0]          rem_reg  [DIV_STEPS];
    logic [31:0]          rem_next [DIV_STEPS];
    logic [30:0]          num_reg  [DIV_STEPS];
    logic [30:0]          num_next [DIV_STEPS];
    logic [30:0]          quo_reg  [DIV_STEPS];
    logic [30:0]          quo_next [DIV_STEPS];
    logic [31:0]          dvs_reg  [DIV_STEPS];
    gpdf_tag_t            tag_reg  [DIV_STEPS];

    // The incoming remainder must be below the divisor; each stage shifts in
    // one numerator bit and subtracts the divisor when it fits.
    always_comb begin
        logic [31:0] r_in;
        logic [30:0] n_in;
        logic [30:0] q_in;
        logic [31:0] d_in;
        logic [33:0] trial;
        for (int i = 0; i < DIV_STEPS; i++) begin
            if (i == 0) begin
                r_in = in_rem;
                n_in = in_num;
                q_in = '0;
                d_in = in_dvs;
            end else begin
                r_in = rem_reg[i-1];
                n_in = num_reg[i-1];
                q_in = quo_reg[i-1];
                d_in = dvs_reg[i-1];
            end
            trial = {1'b0, r_in, n_in[30]} - {2'b00, d_in};
            rem_next[i] = trial[33] ? {r_in[30:0], n_in[30]} : trial[31:0];
            num_next[i] = {n_in[29:0], 1'b0};
            quo_next[i] = {q_in[29:0], ~trial[33]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
        if (en) begin
            dvs_reg[0] <= in_dvs;
            tag_reg[0] <= in_tag;
            for (int i = 1; i < DIV_STEPS; i++) begin
                dvs_reg[i] <= dvs_reg[i-1];
                tag_reg[i] <= tag_reg[i-1];
            end
            for (int i = 0; i < DIV_STEPS; i++) begin
                rem_reg[i] <= rem_next[i];
                num_reg[i] <= num_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_quo   = quo_reg[DIV_STEPS-1];
    assign out_tag   = tag_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/core/gpdf_exp.sv -----
// ============================================================================
// Gaussian evaluator kernel
// exp(-z*z/2)/sqrt(2*pi) in Q30: Taylor core plus table factors.
// ============================================================================
`default_nettype none

module gpdf_exp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire gpdf_pkg::gpdf_side_t in_side,
    output logic                     out_valid,
    output logic [29:0]              out_phi,
    output gpdf_pkg::gpdf_side_t     out_side
);
    import gpdf_pkg::*;

    localparam int STAGES = 17;

    logic [STAGES-1:0] vld_reg;
    gpdf_side_t        side_reg [STAGES];
    logic [7:0]        k_reg    [15];
    logic [26:0]       t_reg    [6];
    logic [59:0]       hold_reg  [1:6];
    logic [59:0]       hold_next [1:6];
    logic [30:0]       a_reg  [7:15];
    logic [30:0]       a_next [7:15];
    logic [29:0]       phi_reg, phi_next;
    logic [61:0]       zz;
    logic [30:0]       a4, a3, a2, a1;
    logic [60:0]       tprod [8:15];
    logic [60:0]       pprod;

    always_comb begin
        zz = 62'(in_side.z) * 62'(in_side.z);
        hold_next[1] = 60'(t_reg[0]) * 60'(RECIP5);
        a4 = ONE30 - 31'(hold_reg[1][58:34]);
        hold_next[2] = 60'(t_reg[1]) * 60'(a4);
        a3 = ONE30 - 31'(hold_reg[2][57:32]);
        hold_next[3] = 60'(t_reg[2]) * 60'(a3);
        hold_next[4] = 60'(hold_reg[3][57:30]) * 60'(RECIP3);
        a2 = ONE30 - 31'(hold_reg[4][59:33]);
        hold_next[5] = 60'(t_reg[4]) * 60'(a2);
        a1 = ONE30 - 31'(hold_reg[5][57:31]);
        hold_next[6] = 60'(t_reg[5]) * 60'(a1);
        a_next[7] = ONE30 - 31'(hold_reg[6][57:30]);
        // One table factor per stage, lowest bit of the eighths count first.
        for (int s = 8; s < 16; s++) begin
            tprod[s] = 61'(a_reg[s-1]) * 61'(exp_tbl(3'(s - 8)));
            a_next[s] = k_reg[s-1][s-8] ? tprod[s][60:30] : a_reg[s-1];
        end
        pprod = 61'(a_reg[15]) * 61'(INV_SQRT_2PI);
        phi_next = pprod[59:30];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
        if (en) begin
            side_reg[0] <= in_side;
            for (int i = 1; i < STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            k_reg[0] <= zz[61:54];
            for (int i = 1; i < 15; i++) begin
                k_reg[i] <= k_reg[i-1];
            end
            t_reg[0] <= zz[53:27];
            for (int i = 1; i < 6; i++) begin
                t_reg[i] <= t_reg[i-1];
            end
            for (int i = 1; i < 7; i++) begin
                hold_reg[i] <= hold_next[i];
            end
            for (int i = 7; i < 16; i++) begin
                a_reg[i] <= a_next[i];
            end
            phi_reg <= phi_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_phi   = phi_reg;
    assign out_side  = side_reg[STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/gpdf_poly.sv -----
// ============================================================================
// Gaussian evaluator tail polynomial and result stage
// Five-term tail polynomial, tail product, and the final output selection.
// ============================================================================
`default_nettype none

module gpdf_poly (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               mode,
    input  wire logic               in_valid,
    input  wire logic [30:0]        in_quo,
    input  wire gpdf_pkg::gpdf_tag_t in_tag,
    output logic                    out_valid,
    output logic [31:0]             out_prob
);
    import gpdf_pkg::*;

    localparam int STAGES = 12;

    logic [STAGES-1:0]  vld_reg;
    logic [30:0]        quo_reg [STAGES-1];
    gpdf_tag_t          tag_reg [STAGES-1];

    logic signed [67:0] p0_reg, p0_next, p2_reg, p2_next, p4_reg, p4_next;
    logic signed [67:0] p6_reg, p6_next, p8_reg, p8_next;
    logic signed [33:0] a1_reg, a1_next, a3_reg, a3_next, a5_reg, a5_next;
    logic signed [33:0] a7_reg, a7_next, f9;
    logic [30:0]        pos9_reg, pos9_next, tail_reg, tail_next;
    logic [60:0]        tprod;
    logic [30:0]        cdf;
    logic [31:0]        prob_reg, prob_next;

    // Q30 product back to Q30, rounding toward zero.
    function automatic logic signed [33:0] trunc30(input logic signed [67:0] p);
        logic signed [67:0] adj;
        adj = p[67] ? p + 68'sd1073741823 : p;
        return 34'(adj >>> 30);
    endfunction

    function automatic logic signed [33:0] tt_s(input logic [30:0] q);
        return $signed({3'b000, q});
    endfunction

    always_comb begin
        p0_next = tt_s(in_quo) * AS_C4;
        a1_next = AS_C3 + trunc30(p0_reg);
        p2_next = tt_s(quo_reg[1]) * a1_reg;
        a3_next = AS_C2 + trunc30(p2_reg);
        p4_next = tt_s(quo_reg[3]) * a3_reg;
        a5_next = AS_C1 + trunc30(p4_reg);
        p6_next = tt_s(quo_reg[5]) * a5_reg;
        a7_next = AS_C0 + trunc30(p6_reg);
        p8_next = tt_s(quo_reg[7]) * a7_reg;
        f9 = trunc30(p8_reg);
        pos9_next = f9[33] ? '0 : f9[30:0];
        tprod = 61'(tag_reg[9].phi) * 61'(pos9_reg);
        tail_next = (tprod[60:30] > ONE30) ? ONE30 : tprod[60:30];
        cdf = tag_reg[10].neg ? tail_reg : ONE30 - tail_reg;
        if (tag_reg[10].far) begin
            prob_next = (mode && !tag_reg[10].neg) ? CDF_ONE : '0;
        end else if (mode) begin
            prob_next = 32'(cdf >> Q_SHIFT);
        end else begin
            prob_next = 32'(quo_reg[10]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
        if (en) begin
            quo_reg[0] <= in_quo;
            tag_reg[0] <= in_tag;
            for (int i = 1; i < STAGES - 1; i++) begin
                quo_reg[i] <= quo_reg[i-1];
                tag_reg[i] <= tag_reg[i-1];
            end
            p0_reg   <= p0_next;
            a1_reg   <= a1_next;
            p2_reg   <= p2_next;
            a3_reg   <= a3_next;
            p4_reg   <= p4_next;
            a5_reg   <= a5_next;
            p6_reg   <= p6_next;
            a7_reg   <= a7_next;
            p8_reg   <= p8_next;
            pos9_reg <= pos9_next;
            tail_reg <= tail_next;
            prob_reg <= prob_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_prob  = prob_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gaussian_pdf_cdf_evaluator.sv -----
// Throughput: one item per cycle; every stage is a register, with two
// 31-stage restoring dividers (one bit per stage) setting most of the depth.
// A stalled m_ side freezes the whole pipeline, and s_tready falls with it.
// Reset clears all valid bits; mean 0, sigma 1.0 and density mode are loaded.
// ============================================================================
// Gaussian density / cumulative distribution evaluator
// Evaluates the normal density or distribution function in fixed point.
// ============================================================================
`default_nettype none

module gaussian_pdf_cdf_evaluator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,     // [31:0] abscissa
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,     // [31:0] prob_value
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    import gpdf_pkg::*;

    logic [31:0] mean_reg;
    logic [30:0] sigma_reg;
    logic        mode_reg;
    logic [30:0] sigma_eff;
    logic        en;

    logic        fr_valid, fr_neg, fr_far;
    logic [31:0] fr_mag;
    logic        d1_valid;
    logic [30:0] d1_quo;
    gpdf_tag_t   d1_tag, fr_tag;
    gpdf_side_t  ex_in, ex_side;
    logic        ex_valid;
    logic [29:0] ex_phi;

    logic [1:0]  mid_vld_reg;
    logic [58:0] zp_reg;
    logic [31:0] den_reg;
    gpdf_tag_t   mid1_tag_reg, mid2_tag_reg;

    logic [31:0] d2_rem, d2_dvs;
    logic [30:0] d2_num;
    logic        d2_valid;
    logic [30:0] d2_quo;
    gpdf_tag_t   d2_tag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg  <= '0;
            sigma_reg <= 31'h0001_0000;
            mode_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MEAN:  mean_reg  <= cfg_wdata;
                REG_SIGMA: sigma_reg <= cfg_wdata[30:0];
                REG_MODE:  mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // A zero sigma behaves as one LSB.
    assign sigma_eff = (sigma_reg == '0) ? 31'd1 : sigma_reg;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;

    gpdf_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid), .in_x(s_tdata),
        .mean(mean_reg), .sigma(sigma_eff),
        .out_valid(fr_valid), .out_mag(fr_mag), .out_neg(fr_neg), .out_far(fr_far)
    );

    assign fr_tag = '{far: fr_far, neg: fr_neg, phi: '0};

    // |z| = |x - mean| / sigma in Q3.28.
    gpdf_div u_div_z (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(fr_valid),
        .in_rem(32'(fr_mag[31:3])),
        .in_num({fr_mag[2:0], 28'd0}),
        .in_dvs({1'b0, sigma_eff}),
        .in_tag(fr_tag),
        .out_valid(d1_valid), .out_quo(d1_quo), .out_tag(d1_tag)
    );

    assign ex_in = '{far: d1_tag.far, neg: d1_tag.neg, z: d1_quo};

    gpdf_exp u_exp (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d1_valid), .in_side(ex_in),
        .out_valid(ex_valid), .out_phi(ex_phi), .out_side(ex_side)
    );

    // Denominator 1 + p*|z| of the tail variable.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_vld_reg <= '0;
        end else if (en) begin
            mid_vld_reg <= {mid_vld_reg[0], ex_valid};
        end
        if (en) begin
            zp_reg       <= 59'(ex_side.z) * 59'(TAIL_P);
            mid1_tag_reg <= '{far: ex_side.far, neg: ex_side.neg, phi: ex_phi};
            den_reg      <= 32'(ONE30) + 32'(zp_reg[58:28]);
            mid2_tag_reg <= mid1_tag_reg;
        end
    end

    // Density divides phi by sigma; the cumulative path forms 2^60 / den.
    always_comb begin
        if (mode_reg) begin
            d2_rem = TAIL_REM0;
            d2_num = '0;
            d2_dvs = den_reg;
        end else begin
            d2_rem = '0;
            d2_num = 31'({mid2_tag_reg.phi, 2'b00});
            d2_dvs = {1'b0, sigma_eff};
        end
    end

    gpdf_div u_div_out (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(mid_vld_reg[1]),
        .in_rem(d2_rem), .in_num(d2_num), .in_dvs(d2_dvs),
        .in_tag(mid2_tag_reg),
        .out_valid(d2_valid), .out_quo(d2_quo), .out_tag(d2_tag)
    );

    gpdf_poly u_poly (
        .aclk(aclk), .aresetn(aresetn), .en(en), .mode(mode_reg),
        .in_valid(d2_valid), .in_quo(d2_quo), .in_tag(d2_tag),
        .out_valid(m_tvalid), .out_prob(m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/gpdf_checker.sv -----
// ============================================================================
// Gaussian evaluator port checker
// Watches the stream ports of the evaluator over time.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module gpdf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    `GPDF_ASSERT(a_m_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result item dropped while stalled")
    `GPDF_ASSERT(a_m_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result item changed while stalled")
    `GPDF_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `GPDF_ASSERT_ALWAYS(a_ready_follows, aclk, s_tready == (!m_tvalid || m_tready), "input ready does not follow the pipeline stall")

endmodule

bind gaussian_pdf_cdf_evaluator gpdf_checker u_gpdf_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

`default_nettype wire
